// ===== hdl/dictionary_entry_field_selector_macros.svh =====
// Assertion macros shared by the field selector RTL.
`ifndef DICTIONARY_ENTRY_FIELD_SELECTOR_MACROS_SVH
`define DICTIONARY_ENTRY_FIELD_SELECTOR_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define DESF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("field selector check failed");

// Next-cycle implication, checked while out of reset.
`define DESF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("field selector check failed");

`endif

// ===== hdl/desf_pkg.sv =====
// Types, codes and helper functions of the dictionary entry field selector.
package desf_pkg;

  localparam logic [3:0] MAX_SEQUENCE = 4'd8;

  localparam logic [7:0] CH_M = 8'h6d;
  localparam logic [7:0] CH_L = 8'h6c;
  localparam logic [7:0] CH_G = 8'h67;
  localparam logic [7:0] CH_X = 8'h78;
  localparam logic [7:0] CH_H = 8'h68;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_Y = 8'h79;
  localparam logic [7:0] CH_K = 8'h6b;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_UW = 8'h57;
  localparam logic [7:0] CH_UP = 8'h50;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5a;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_SIZE  = 3'd1,
    PH_SIZED = 3'd2,
    PH_NUL   = 3'd3,
    PH_TOEND = 3'd4,
    PH_DONE  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    MODE_SEQUENCE = 2'd0,
    MODE_TAGGED   = 2'd1,
    MODE_WHOLE    = 2'd2
  } mode_e;

  typedef enum logic {
    CFG_TYPE_SEQUENCE   = 1'b0,
    CFG_SEQUENCE_LENGTH = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic        found;
    logic [7:0]  ftype;
    logic [31:0] start;
    logic [31:0] length;
    logic        latin;
    logic [1:0]  mode;
  } result_t;

  function automatic logic is_upper(input logic [7:0] t);
    return (t >= CH_UA) && (t <= CH_UZ);
  endfunction

  function automatic logic is_text_field(input logic [7:0] t);
    return (t == CH_M) || (t == CH_L) || (t == CH_G) || (t == CH_X) || (t == CH_H);
  endfunction

  function automatic logic is_field_tag(input logic [7:0] t);
    return is_text_field(t) || (t == CH_T) || (t == CH_Y) || (t == CH_K)
        || (t == CH_R) || (t == CH_UW) || (t == CH_UP);
  endfunction

endpackage

// ===== hdl/desf_parser.sv =====
// Byte-wise entry parser: field state registers and result selection.
module desf_parser
  import desf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_en_i,
  input  logic [7:0]  entry_byte_i,
  input  logic        last_byte_i,
  input  logic [63:0] type_seq_i,
  input  logic [3:0]  seq_len_i,
  output logic        result_en_o,
  output result_t     result_o
);

  logic [31:0] pos_q, pos_d;
  phase_e      phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] rem_q, rem_d;
  logic [7:0]  ctype_q, ctype_d;
  logic [31:0] cstart_q, cstart_d;
  logic [3:0]  idx_q, idx_d;
  logic [63:0] first_span_q, first_span_d;
  logic [8:0]  first_meta_q, first_meta_d;
  logic [63:0] text_span_q, text_span_d;
  logic [8:0]  text_meta_q, text_meta_d;
  logic [7:0]  lead_q, lead_d;
  logic        nul_q, nul_d;
  mode_e       mode_q, mode_d;
  logic        open_q;

  logic [3:0]  eff_n;
  logic        consumed;
  logic        rec_en;
  logic [31:0] rec_start;
  logic [31:0] rec_len;
  logic [31:0] pos_next;
  mode_e       out_mode;

  assign eff_n    = (seq_len_i > MAX_SEQUENCE) ? MAX_SEQUENCE : seq_len_i;
  assign pos_next = pos_q + 32'd1;

  // Parser next state for the byte at the input.
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    ctype_d   = ctype_q;
    cstart_d  = cstart_q;
    idx_d     = idx_q;
    lead_d    = lead_q;
    mode_d    = mode_q;
    consumed  = 1'b0;
    rec_en    = 1'b0;
    rec_start = cstart_q;
    rec_len   = 32'd0;

    // Latch the mode on the first byte of an entry.
    if (!open_q) begin
      lead_d = entry_byte_i;
      if (eff_n != 4'd0) begin
        mode_d = MODE_SEQUENCE;
      end else if (is_field_tag(entry_byte_i)) begin
        mode_d = MODE_TAGGED;
      end else begin
        mode_d  = MODE_WHOLE;
        phase_d = PH_DONE;
      end
    end
    nul_d = nul_q | (entry_byte_i == 8'd0);

    if (phase_d == PH_START) begin
      if (mode_d == MODE_SEQUENCE) begin
        if (idx_q >= eff_n) begin
          phase_d  = PH_DONE;
          consumed = 1'b1;
        end else begin
          ctype_d = type_seq_i[{idx_q[2:0], 3'b000} +: 8];
          idx_d   = idx_q + 4'd1;
          if (is_upper(ctype_d)) begin
            phase_d = PH_SIZE;
            cnt_d   = 2'd0;
            acc_d   = 32'd0;
          end else begin
            cstart_d = pos_q;
            phase_d  = (idx_d == eff_n) ? PH_TOEND : PH_NUL;
          end
        end
      end else begin
        ctype_d  = entry_byte_i;
        consumed = 1'b1;
        if (is_upper(entry_byte_i)) begin
          phase_d = PH_SIZE;
          cnt_d   = 2'd0;
          acc_d   = 32'd0;
        end else begin
          phase_d  = PH_NUL;
          cstart_d = pos_next;
        end
      end
    end

    if (!consumed) begin
      unique case (phase_d)
        PH_SIZE: begin
          acc_d = {acc_d[23:0], entry_byte_i};
          if (cnt_d == 2'd3) begin
            cnt_d    = 2'd0;
            cstart_d = pos_next;
            if (acc_d == 32'd0) begin
              rec_en    = 1'b1;
              rec_start = pos_next;
              rec_len   = 32'd0;
            end else begin
              rem_d   = acc_d;
              phase_d = PH_SIZED;
            end
          end else begin
            cnt_d = cnt_d + 2'd1;
          end
        end
        PH_SIZED: begin
          rem_d = rem_d - 32'd1;
          if (rem_d == 32'd0) begin
            rec_en    = 1'b1;
            rec_start = cstart_d;
            rec_len   = acc_d;
          end
        end
        PH_NUL: begin
          if (entry_byte_i == 8'd0) begin
            rec_en    = 1'b1;
            rec_start = cstart_d;
            rec_len   = pos_q - cstart_d;
          end
        end
        default: ;
      endcase
    end

    // A finished field returns to field start, or stops once the sequence is used up.
    if (rec_en) begin
      phase_d = ((mode_d == MODE_SEQUENCE) && (idx_d >= eff_n)) ? PH_DONE : PH_START;
    end

    // Close the open field at the end of the entry; drop a truncated size.
    if (last_byte_i) begin
      if ((phase_d == PH_SIZED) || (phase_d == PH_NUL) || (phase_d == PH_TOEND)) begin
        rec_en    = 1'b1;
        rec_start = cstart_d;
        rec_len   = pos_next - cstart_d;
        phase_d   = PH_DONE;
      end else if (phase_d == PH_SIZE) begin
        phase_d = PH_DONE;
      end
    end

    first_span_d = first_span_q;
    first_meta_d = first_meta_q;
    text_span_d  = text_span_q;
    text_meta_d  = text_meta_q;
    if (rec_en && !first_meta_q[8]) begin
      first_span_d = {rec_start, rec_len};
      first_meta_d = {1'b1, ctype_d};
    end
    if (rec_en && is_text_field(ctype_d) && !text_meta_q[8]) begin
      text_span_d = {rec_start, rec_len};
      text_meta_d = {1'b1, ctype_d};
    end
  end

  // Result selection on the final byte.
  always_comb begin
    out_mode = mode_d;
    if ((mode_d == MODE_TAGGED) && !is_upper(lead_d) && !nul_d) begin
      out_mode = MODE_WHOLE;
    end
    result_o = '0;
    result_o.mode = out_mode;
    if (out_mode == MODE_WHOLE) begin
      result_o.found  = 1'b1;
      result_o.ftype  = CH_M;
      result_o.length = pos_next;
    end else if (text_meta_d[8]) begin
      result_o.found  = 1'b1;
      result_o.ftype  = text_meta_d[7:0];
      result_o.start  = text_span_d[63:32];
      result_o.length = text_span_d[31:0];
      result_o.latin  = (text_meta_d[7:0] == CH_L);
    end else if (first_meta_d[8]) begin
      result_o.found  = 1'b1;
      result_o.ftype  = first_meta_d[7:0];
      result_o.start  = first_span_d[63:32];
      result_o.length = first_span_d[31:0];
    end
  end

  assign result_en_o = byte_en_i & last_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      phase_q      <= PH_START;
      cnt_q        <= '0;
      acc_q        <= '0;
      rem_q        <= '0;
      ctype_q      <= '0;
      cstart_q     <= '0;
      idx_q        <= '0;
      first_span_q <= '0;
      first_meta_q <= '0;
      text_span_q  <= '0;
      text_meta_q  <= '0;
      lead_q       <= '0;
      nul_q        <= 1'b0;
      mode_q       <= MODE_SEQUENCE;
      open_q       <= 1'b0;
    end else if (byte_en_i) begin
      if (last_byte_i) begin
        // Clear all per-entry state for the next entry.
        pos_q        <= '0;
        phase_q      <= PH_START;
        cnt_q        <= '0;
        acc_q        <= '0;
        rem_q        <= '0;
        ctype_q      <= '0;
        cstart_q     <= '0;
        idx_q        <= '0;
        first_span_q <= '0;
        first_meta_q <= '0;
        text_span_q  <= '0;
        text_meta_q  <= '0;
        lead_q       <= '0;
        nul_q        <= 1'b0;
        mode_q       <= MODE_SEQUENCE;
        open_q       <= 1'b0;
      end else begin
        pos_q        <= pos_next;
        phase_q      <= phase_d;
        cnt_q        <= cnt_d;
        acc_q        <= acc_d;
        rem_q        <= rem_d;
        ctype_q      <= ctype_d;
        cstart_q     <= cstart_d;
        idx_q        <= idx_d;
        first_span_q <= first_span_d;
        first_meta_q <= first_meta_d;
        text_span_q  <= text_span_d;
        text_meta_q  <= text_meta_d;
        lead_q       <= lead_d;
        nul_q        <= nul_d;
        mode_q       <= mode_d;
        open_q       <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/dictionary_entry_field_selector.sv =====
// Dictionary entry field selector top level: config registers, parser, result register.
// Takes one entry byte per clock cycle unless the input stalls; each accepted byte
// updates the parser registers, so bytes stream in back to back. On the word that carries
// tlast the selected field is loaded into the result register and shown on the master
// side the next cycle. The input stalls only while that register holds a result that
// the downstream side has not taken. Configuration is written through a plain write
// port and should change only between entries.
`include "dictionary_entry_field_selector_macros.svh"

module dictionary_entry_field_selector
  import desf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] entry_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] field_found, [8:1] field_type, [40:9] field_start, [72:41] field_length,
  // [73] needs_latin1, [75:74] parse_mode, [79:76] zero
  output logic [79:0] m_axis_tdata
);

  logic [63:0] type_seq_q;
  logic [3:0]  seq_len_q;
  logic        in_accept;
  logic        res_en;
  result_t     res;
  logic        out_valid_q;
  result_t     out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_seq_q <= '0;
      seq_len_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TYPE_SEQUENCE:   type_seq_q <= cfg_data_i;
        CFG_SEQUENCE_LENGTH: seq_len_q  <= cfg_data_i[3:0];
      endcase
    end
  end

  // Accept a word whenever the result register is free or being drained.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  desf_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_en_i    (in_accept),
    .entry_byte_i (s_axis_tdata),
    .last_byte_i  (s_axis_tlast),
    .type_seq_i   (type_seq_q),
    .seq_len_i    (seq_len_q),
    .result_en_o  (res_en),
    .result_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_en) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_en) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.mode, out_q.latin, out_q.length, out_q.start,
                          out_q.ftype, out_q.found};

  `DESF_ASSERT_NEXT(a_result_shown, clk_i, rst_ni, res_en, out_valid_q)
  `DESF_ASSERT_NOW(a_mode_code, clk_i, rst_ni, out_valid_q, out_q.mode != 2'd3)
  `DESF_ASSERT_NOW(a_latin_type, clk_i, rst_ni, out_valid_q && out_q.latin, out_q.ftype == CH_L)
  `DESF_ASSERT_NOW(a_empty_clear, clk_i, rst_ni, out_valid_q && !out_q.found,
                   (out_q.ftype == 8'd0) && (out_q.length == 32'd0))

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the dictionary entry field selector: directed entries, then random.
module tb_top;
  import desf_pkg::*;

  localparam int STALL_LIMIT  = 200;
  localparam int SETTLE       = 8;
  localparam int RANDOM_BYTES = 1900;

  typedef struct packed {
    logic [63:0] seq;
    logic [3:0]  len;
    logic [2:0]  nb;
    logic [47:0] data;   // first byte of the entry in the lowest byte
    logic        typed;
    result_t     want;
  } probe_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] entry_byte
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [0] field_found, [8:1] field_type, [40:9] field_start, [72:41] field_length,
  // [73] needs_latin1, [75:74] parse_mode, [79:76] zero
  logic [79:0] m_axis_tdata;

  dictionary_entry_field_selector uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Shadow of the configuration registers
  logic [63:0] seq_reg;
  logic [3:0]  len_reg;

  // Shadow of the parser state
  logic [31:0] pos_q;
  phase_e      phase_q;
  int          size_cnt;
  logic [31:0] size_acc;
  logic [31:0] remain;
  logic [7:0]  cur_type;
  logic [31:0] cur_start;
  int          seq_idx;
  logic        first_valid;
  logic [7:0]  first_type;
  logic [31:0] first_start;
  logic [31:0] first_len;
  logic        text_valid;
  logic [7:0]  text_type;
  logic [31:0] text_start;
  logic [31:0] text_len;
  logic [7:0]  lead_byte;
  logic        saw_nul;
  mode_e       mode_q;
  logic        open_q;

  result_t     predicted_fields[$];
  probe_row_t  probe_rows[$];
  logic [7:0]  entry_bytes[$];
  int          mismatch_count;
  bit          no_idle;
  bit          pend_typed;
  result_t     pend_want;

  function automatic bit is_cap(input logic [7:0] t);
    return (t >= 8'h41) && (t <= 8'h5a);
  endfunction

  function automatic bit is_text(input logic [7:0] t);
    return (t == CH_M) || (t == CH_L) || (t == CH_G) || (t == CH_X) || (t == CH_H);
  endfunction

  function automatic bit is_tag(input logic [7:0] t);
    return is_text(t) || (t == CH_T) || (t == CH_Y) || (t == CH_K) || (t == CH_R)
        || (t == CH_UW) || (t == CH_UP);
  endfunction

  function automatic int seq_count();
    return (len_reg > MAX_SEQUENCE) ? int'(MAX_SEQUENCE) : int'(len_reg);
  endfunction

  function automatic result_t mk_pick(input logic found, input logic [7:0] ftype,
                                      input logic [31:0] start, input logic [31:0] length,
                                      input logic latin, input mode_e mode);
    result_t r;
    r.found  = found;
    r.ftype  = ftype;
    r.start  = start;
    r.length = length;
    r.latin  = latin;
    r.mode   = mode;
    return r;
  endfunction

  function automatic logic [7:0] pick_type(input bit lead);
    case ($urandom_range(0, lead ? 10 : 12))
      0:       return CH_M;
      1:       return CH_L;
      2:       return CH_G;
      3:       return CH_X;
      4:       return CH_H;
      5:       return CH_T;
      6:       return CH_Y;
      7:       return CH_K;
      8:       return CH_R;
      9:       return CH_UW;
      10:      return CH_UP;
      11:      return 8'(8'h41 + $urandom_range(0, 25));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] type_seq_word();
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[8*i +: 8] = pick_type(1'b0);
    return w;
  endfunction

  task automatic reset_entry_state();
    pos_q       = '0;
    phase_q     = PH_START;
    size_cnt    = 0;
    size_acc    = '0;
    remain      = '0;
    cur_type    = '0;
    cur_start   = '0;
    seq_idx     = 0;
    first_valid = 1'b0;
    first_type  = '0;
    first_start = '0;
    first_len   = '0;
    text_valid  = 1'b0;
    text_type   = '0;
    text_start  = '0;
    text_len    = '0;
    lead_byte   = '0;
    saw_nul     = 1'b0;
    mode_q      = MODE_SEQUENCE;
    open_q      = 1'b0;
  endtask

  task automatic log_field(input logic [31:0] start, input logic [31:0] length);
    if (!first_valid) begin
      first_valid = 1'b1;
      first_type  = cur_type;
      first_start = start;
      first_len   = length;
    end
    if (is_text(cur_type) && !text_valid) begin
      text_valid = 1'b1;
      text_type  = cur_type;
      text_start = start;
      text_len   = length;
    end
  endtask

  task automatic end_field(input logic [31:0] start, input logic [31:0] length);
    log_field(start, length);
    if (mode_q == MODE_SEQUENCE && seq_idx >= seq_count()) phase_q = PH_DONE;
    else phase_q = PH_START;
  endtask

  // Advance the shadow parser by one accepted word; emit is set on the entry's last byte.
  task automatic parse_entry_byte(input logic [7:0] b, input logic lst,
                                  output bit emit, output result_t r);
    logic [31:0] p;
    bit          took;
    int          n;
    mode_e       m;
    p    = pos_q;
    took = 1'b0;
    emit = 1'b0;
    r    = '0;
    n    = seq_count();
    if (!open_q) begin
      open_q    = 1'b1;
      lead_byte = b;
      if (n != 0) mode_q = MODE_SEQUENCE;
      else if (is_tag(b)) mode_q = MODE_TAGGED;
      else begin
        mode_q  = MODE_WHOLE;
        phase_q = PH_DONE;
      end
    end
    if (b == 8'h00) saw_nul = 1'b1;

    if (phase_q == PH_START) begin
      if (mode_q == MODE_SEQUENCE) begin
        if (seq_idx >= n) begin
          phase_q = PH_DONE;
          took    = 1'b1;
        end else begin
          cur_type = seq_reg[8*seq_idx +: 8];
          seq_idx++;
          if (is_cap(cur_type)) begin
            phase_q  = PH_SIZE;
            size_cnt = 0;
            size_acc = '0;
          end else begin
            cur_start = p;
            phase_q   = (seq_idx == n) ? PH_TOEND : PH_NUL;
          end
        end
      end else begin
        // self-tagged: this byte is the type and carries no content
        cur_type = b;
        took     = 1'b1;
        if (is_cap(b)) begin
          phase_q  = PH_SIZE;
          size_cnt = 0;
          size_acc = '0;
        end else begin
          phase_q   = PH_NUL;
          cur_start = p + 32'd1;
        end
      end
    end

    if (!took) begin
      case (phase_q)
        PH_SIZE: begin
          size_acc = {size_acc[23:0], b};
          if (size_cnt == 3) begin
            size_cnt  = 0;
            cur_start = p + 32'd1;
            if (size_acc == '0) end_field(cur_start, '0);
            else begin
              remain  = size_acc;
              phase_q = PH_SIZED;
            end
          end else begin
            size_cnt++;
          end
        end
        PH_SIZED: begin
          remain = remain - 32'd1;
          if (remain == '0) end_field(cur_start, size_acc);
        end
        PH_NUL: begin
          if (b == 8'h00) end_field(cur_start, p - cur_start);
        end
        default: ;
      endcase
    end

    pos_q = p + 32'd1;
    if (lst) begin
      if (phase_q == PH_SIZED || phase_q == PH_NUL || phase_q == PH_TOEND) begin
        log_field(cur_start, p + 32'd1 - cur_start);
        phase_q = PH_DONE;
      end else if (phase_q == PH_SIZE) begin
        // size prefix cut short: stop, no field
        phase_q = PH_DONE;
      end
      m = mode_q;
      if (m == MODE_TAGGED && !is_cap(lead_byte) && !saw_nul) m = MODE_WHOLE;
      if (m == MODE_WHOLE) r = mk_pick(1'b1, CH_M, '0, p + 32'd1, 1'b0, m);
      else if (text_valid)
        r = mk_pick(1'b1, text_type, text_start, text_len, text_type == CH_L, m);
      else if (first_valid) r = mk_pick(1'b1, first_type, first_start, first_len, 1'b0, m);
      else r = mk_pick(1'b0, '0, '0, '0, 1'b0, m);
      emit = 1'b1;
      reset_entry_state();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int      gap;
    bit      emit;
    result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_entry_byte(b, lst, emit, r);
    if (emit) predicted_fields.insert(predicted_fields.size(), pend_typed ? pend_want : r);
  endtask

  // Hold the input idle until every pending result is out and the block has settled.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (predicted_fields.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [63:0] seq, input logic [3:0] len);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_TYPE_SEQUENCE;
    cfg_data_i  <= seq;
    @(posedge clk_i);
    cfg_index_i <= CFG_SEQUENCE_LENGTH;
    cfg_data_i  <= {60'd0, len};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    seq_reg = seq;
    len_reg = len;
  endtask

  task automatic add_row(input logic [63:0] seq, input logic [3:0] len, input logic [2:0] nb,
                         input logic [47:0] data, input logic typed, input result_t want);
    probe_row_t row;
    row.seq   = seq;
    row.len   = len;
    row.nb    = nb;
    row.data  = data;
    row.typed = typed;
    row.want  = want;
    probe_rows.insert(probe_rows.size(), row);
  endtask

  task automatic add_entry_byte(input logic [7:0] b);
    entry_bytes.insert(entry_bytes.size(), b);
  endtask

  // Fill entry_bytes with one entry shaped by the current configuration.
  task automatic build_entry();
    int          kind;
    int          nf;
    int          sz;
    int          cut;
    logic [7:0]  t;
    entry_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      repeat ($urandom_range(1, 8)) add_entry_byte(8'($urandom_range(0, 255)));
    end else begin
      nf = (seq_count() != 0) ? seq_count() : $urandom_range(1, 4);
      for (int i = 0; i < nf; i++) begin
        if (seq_count() != 0) t = seq_reg[8*i +: 8];
        else begin
          t = pick_type(i == 0);
          add_entry_byte(t);
        end
        if (is_cap(t)) begin
          if ($urandom_range(0, 9) == 0) begin
            // oversized prefix, cut at the entry end
            repeat (4) add_entry_byte(8'($urandom_range(0, 255)));
          end else begin
            sz = $urandom_range(0, 5);
            repeat (3) add_entry_byte(8'h00);
            add_entry_byte(8'(sz));
            repeat (sz) add_entry_byte(8'($urandom_range(0, 255)));
          end
        end else begin
          repeat ($urandom_range(0, 5)) add_entry_byte(8'($urandom_range(1, 255)));
          if (i != nf - 1 || $urandom_range(0, 1) == 1) add_entry_byte(8'h00);
        end
      end
      if (kind == 2 && entry_bytes.size() > 1) begin
        cut = $urandom_range(1, entry_bytes.size() - 1);
        while (entry_bytes.size() > cut) void'(entry_bytes.pop_back());
      end else if (kind == 3) begin
        repeat ($urandom_range(1, 4)) add_entry_byte(8'($urandom_range(0, 255)));
      end
    end
    if (entry_bytes.size() == 0) add_entry_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : stimulus
    logic [63:0] seq;
    logic [3:0]  len;
    int          sent;
    probe_row_t  row;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_TYPE_SEQUENCE;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    seq_reg        = '0;
    len_reg        = '0;
    mismatch_count = 0;
    no_idle        = 1'b0;
    pend_typed     = 1'b0;
    pend_want      = '0;
    reset_entry_state();

    // whole-entry fallback on a non-type first byte, both byte extremes
    add_row(64'h0, 4'd0, 3'd1, 48'h41, 1'b1, mk_pick(1'b1, CH_M, 0, 1, 1'b0, MODE_WHOLE));
    add_row(64'h0, 4'd0, 3'd2, 48'h00ff, 1'b1, mk_pick(1'b1, CH_M, 0, 2, 1'b0, MODE_WHOLE));
    // self-tagged Latin-1 field closed by NUL
    add_row(64'h0, 4'd0, 3'd3, 48'h00616c, 1'b1, mk_pick(1'b1, CH_L, 1, 1, 1'b1, MODE_TAGGED));
    // lower-case tag without any NUL falls back to whole entry
    add_row(64'h0, 4'd0, 3'd2, 48'h616d, 1'b1, mk_pick(1'b1, CH_M, 0, 2, 1'b0, MODE_WHOLE));
    // size prefix cut short by the last byte
    add_row(64'h0, 4'd0, 3'd3, 48'h000057, 1'b1, mk_pick(1'b0, 0, 0, 0, 1'b0, MODE_TAGGED));
    // type byte as the last byte
    add_row(64'h0, 4'd0, 3'd3, 48'h6d006b, 1'b0, '0);
    // size running past the entry end
    add_row(64'h0, 4'd0, 3'd6, 48'h610900000057, 1'b0, '0);
    // last sequence type runs to the end
    add_row(64'h6d, 4'd1, 3'd2, 48'h6261, 1'b1, mk_pick(1'b1, CH_M, 0, 2, 1'b0, MODE_SEQUENCE));
    // oversized sequence length saturates
    add_row(64'h6b6b6b6b6b6b6b6b, 4'd15, 3'd2, 48'h0061, 1'b0, '0);
    // sequence used up, trailing bytes dropped
    add_row(64'h57, 4'd1, 3'd5, 48'h7a00000000, 1'b0, '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (probe_rows[i]) begin
      row = probe_rows[i];
      if (row.seq != seq_reg || row.len != len_reg) begin
        drain();
        set_config(row.seq, row.len);
      end
      pend_typed = row.typed;
      pend_want  = row.want;
      for (int j = 0; j < int'(row.nb); j++)
        send_byte(row.data[8*j +: 8], j == int'(row.nb) - 1);
      pend_typed = 1'b0;
    end

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      drain();
      case ($urandom_range(0, 7))
        0, 1, 2, 3: begin
          seq = ($urandom_range(0, 1) == 1) ? '0 : {$urandom, $urandom};
          len = 4'd0;
        end
        4: begin
          seq = type_seq_word();
          len = 4'($urandom_range(1, 8));
        end
        5: begin
          seq = ($urandom_range(0, 1) == 1) ? '1 : '0;
          len = MAX_SEQUENCE;
        end
        6: begin
          seq = type_seq_word();
          len = 4'($urandom_range(9, 15));
        end
        default: begin
          seq = {$urandom, $urandom};
          len = 4'($urandom_range(1, 8));
        end
      endcase
      set_config(seq, len);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(6, 16)) begin
        build_entry();
        foreach (entry_bytes[k]) send_byte(entry_bytes[k], k == entry_bytes.size() - 1);
        sent += entry_bytes.size();
      end
    end

    drain();
    if (mismatch_count == 0 && predicted_fields.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : result_sink
    int      hold;
    result_t got;
    result_t want;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 6);
      repeat (hold) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.found  = m_axis_tdata[0];
      got.ftype  = m_axis_tdata[8:1];
      got.start  = m_axis_tdata[40:9];
      got.length = m_axis_tdata[72:41];
      got.latin  = m_axis_tdata[73];
      got.mode   = m_axis_tdata[75:74];
      if (predicted_fields.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected word: found=%0d type=%h start=%0d len=%0d latin=%0d mode=%0d",
                   got.found, got.ftype, got.start, got.length, got.latin, got.mode);
        mismatch_count++;
      end else begin
        want = predicted_fields.pop_front();
        if (got.found !== want.found || got.ftype !== want.ftype || got.start !== want.start
            || got.length !== want.length || got.latin !== want.latin
            || got.mode !== want.mode) begin
          if (mismatch_count < 10) begin
            $display("mismatch: exp found=%0d type=%h start=%0d len=%0d latin=%0d mode=%0d",
                     want.found, want.ftype, want.start, want.length, want.latin, want.mode);
            $display("          got found=%0d type=%h start=%0d len=%0d latin=%0d mode=%0d",
                     got.found, got.ftype, got.start, got.length, got.latin, got.mode);
          end
          mismatch_count++;
        end
      end
    end
  end

  // End the run if neither side moves a word for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/desf_pkg.sv
hdl/desf_parser.sv
hdl/dictionary_entry_field_selector.sv
tb/sv/tb_top.sv
